[rtl/rvamo_pkg.sv]
// ============================================================================
// rvamo_pkg
// Shared types and codes for the atomic memory operation unit.
// ============================================================================
package rvamo_pkg;

    localparam int XLEN = 64;

    localparam logic [4:0] OP_ADD  = 5'h00;
    localparam logic [4:0] OP_SWAP = 5'h01;
    localparam logic [4:0] OP_LR   = 5'h02;
    localparam logic [4:0] OP_SC   = 5'h03;
    localparam logic [4:0] OP_XOR  = 5'h04;
    localparam logic [4:0] OP_OR   = 5'h08;
    localparam logic [4:0] OP_AND  = 5'h0C;
    localparam logic [4:0] OP_MIN  = 5'h10;
    localparam logic [4:0] OP_MAX  = 5'h14;
    localparam logic [4:0] OP_MINU = 5'h18;
    localparam logic [4:0] OP_MAXU = 5'h1C;

    localparam logic [2:0] SIZE_WORD   = 3'd2;
    localparam logic [2:0] SIZE_DOUBLE = 3'd3;

    localparam logic [1:0] TRAP_NONE       = 2'd0;
    localparam logic [1:0] TRAP_MISALIGNED = 2'd1;
    localparam logic [1:0] TRAP_ILLEGAL    = 2'd2;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic [4:0]      action;
        logic [2:0]      size_code;
        logic [XLEN-1:0] address;
        logic [XLEN-1:0] operand;
        logic [XLEN-1:0] memory_data;
        logic            read_fault;
        logic            write_fault;
        logic [4:0]      dest_reg;
        logic [XLEN-1:0] inst_addr;
    } in_item_t;

    typedef struct packed {
        logic            mem_read;
        logic            mem_write;
        logic [XLEN-1:0] write_data;
        logic            rd_write;
        logic [4:0]      rd_index;
        logic [XLEN-1:0] rd_value;
        logic [1:0]      trap_kind;
        logic [XLEN-1:0] trap_value;
    } out_item_t;

    typedef struct packed {
        logic            set;
        logic            clear;
        logic [XLEN-1:0] address;
    } resv_update_t;

endpackage

[rtl/rvamo_alu.sv]
// ============================================================================
// rvamo_alu
// Computes the value an AMO stores: add, swap, logic ops and min/max.
// ============================================================================
module rvamo_alu
(
    input  logic [4:0]               action,
    input  logic                     word,
    input  logic [rvamo_pkg::XLEN-1:0] mem_value,
    input  logic [rvamo_pkg::XLEN-1:0] src_value,
    output logic [rvamo_pkg::XLEN-1:0] result
);
    import rvamo_pkg::*;

    logic [XLEN-1:0] mask;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic            is_signed;
    logic [XLEN:0]   a_ext;
    logic [XLEN:0]   b_ext;
    logic            a_lt_b;
    logic [XLEN-1:0] raw;

    assign mask      = word ? {{(XLEN-32){1'b0}}, 32'hFFFF_FFFF} : {XLEN{1'b1}};
    assign a         = mem_value & mask;
    assign b         = src_value & mask;
    assign is_signed = (action == OP_MIN) || (action == OP_MAX);

    // Both operands widen by one bit so one signed compare serves all four cases.
    assign a_ext = word ? {{(XLEN-31){is_signed & a[31]}}, a[31:0]}
                        : {is_signed & a[XLEN-1], a};
    assign b_ext = word ? {{(XLEN-31){is_signed & b[31]}}, b[31:0]}
                        : {is_signed & b[XLEN-1], b};
    assign a_lt_b = $signed(a_ext) < $signed(b_ext);

    always_comb
    begin
        unique case (action)
            OP_ADD:  raw = a + b;
            OP_SWAP: raw = b;
            OP_XOR:  raw = a ^ b;
            OP_OR:   raw = a | b;
            OP_AND:  raw = a & b;
            OP_MIN:  raw = a_lt_b ? a : b;
            OP_MAX:  raw = a_lt_b ? b : a;
            OP_MINU: raw = a_lt_b ? a : b;
            default: raw = a_lt_b ? b : a;
        endcase
    end

    assign result = raw & mask;

endmodule

[rtl/rvamo_exec.sv]
// ============================================================================
// rvamo_exec
// Decodes one instruction, checks traps and the reservation, forms the result.
// ============================================================================
module rvamo_exec
(
    input  rvamo_pkg::in_item_t       item,
    input  logic                      resv_valid,
    input  logic [rvamo_pkg::XLEN-1:0] resv_addr,
    output rvamo_pkg::out_item_t      result,
    output rvamo_pkg::resv_update_t   resv_update
);
    import rvamo_pkg::*;

    logic            known_op;
    logic            legal_size;
    logic            word;
    logic            misaligned;
    logic            is_lr;
    logic            is_sc;
    logic            sc_match;
    logic [XLEN-1:0] mask;
    logic [XLEN-1:0] old_value;
    logic [XLEN-1:0] amo_value;

    always_comb
    begin
        unique case (item.action)
            OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR, OP_AND,
            OP_MIN, OP_MAX, OP_MINU, OP_MAXU: known_op = 1'b1;
            default:                          known_op = 1'b0;
        endcase
    end

    assign legal_size = (item.size_code == SIZE_WORD) || (item.size_code == SIZE_DOUBLE);
    assign word       = item.size_code == SIZE_WORD;
    assign misaligned = word ? (item.address[1:0] != 2'b00) : (item.address[2:0] != 3'b000);
    assign is_lr      = item.action == OP_LR;
    assign is_sc      = item.action == OP_SC;
    assign sc_match   = resv_valid && (resv_addr == item.address);
    assign mask       = word ? {{(XLEN-32){1'b0}}, 32'hFFFF_FFFF} : {XLEN{1'b1}};
    assign old_value  = word ? {{(XLEN-32){item.memory_data[31]}}, item.memory_data[31:0]}
                             : item.memory_data;

    rvamo_alu u_alu
    (
        .action    (item.action),
        .word      (word),
        .mem_value (item.memory_data),
        .src_value (item.operand),
        .result    (amo_value)
    );

    always_comb
    begin
        result              = '0;
        result.rd_index     = item.dest_reg;
        resv_update         = '0;
        resv_update.address = item.address;
        priority if (!legal_size || !known_op)
        begin
            result.trap_kind  = TRAP_ILLEGAL;
            result.trap_value = item.inst_addr;
        end
        else if ((is_lr || is_sc) && misaligned)
        begin
            result.trap_kind  = TRAP_MISALIGNED;
            result.trap_value = item.address;
        end
        else if (is_lr)
        begin
            result.mem_read = 1'b1;
            if (!item.read_fault)
            begin
                result.rd_write = 1'b1;
                result.rd_value = old_value;
                resv_update.set = 1'b1;
            end
        end
        else if (is_sc)
        begin
            result.rd_write   = 1'b1;
            resv_update.clear = 1'b1;
            if (sc_match)
            begin
                result.mem_write  = 1'b1;
                result.write_data = item.operand & mask;
                result.rd_value   = {{(XLEN-1){1'b0}}, item.write_fault};
            end
            else
            begin
                result.rd_value = {{(XLEN-1){1'b0}}, 1'b1};
            end
        end
        else
        begin
            result.mem_read = 1'b1;
            if (!item.read_fault)
            begin
                result.mem_write  = 1'b1;
                result.write_data = amo_value;
                if (!item.write_fault)
                begin
                    result.rd_write = 1'b1;
                    result.rd_value = old_value;
                end
            end
        end
    end

endmodule

[rtl/riscv_atomic_memory_op_unit_core.sv]
// ============================================================================
// riscv_atomic_memory_op_unit_core
// RV64 A-extension unit: executes one LR, SC or AMO instruction per transfer.
// ============================================================================
// Each input transfer is captured in an input register, executed by the
// combinational decode, reservation check and ALU logic, and held in an
// output register; a new transfer is taken every cycle while the output
// side keeps up. The single reservation is read and updated as an
// instruction moves into the output register, so instructions see it in
// order.
module riscv_atomic_memory_op_unit_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // size_code, address, operand, memory_data, read_fault, write_fault,
    // dest_reg, inst_addr, zero fill
    input  logic [rvamo_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [rvamo_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mem_read, mem_write, write_data, rd_write, rd_index, rd_value, trap_value
    output logic [rvamo_pkg::OUT_DATA_W-1:0] m_tdata,
    // trap_kind
    output logic [rvamo_pkg::OUT_USER_W-1:0] m_tuser
);
    import rvamo_pkg::*;

    logic            in_valid_reg;
    in_item_t        in_item_reg;
    in_item_t        in_item_next;
    logic            out_valid_reg;
    out_item_t       out_item_reg;
    out_item_t       exec_result;
    resv_update_t    resv_update;
    logic            resv_valid_reg;
    logic [XLEN-1:0] resv_addr_reg;
    logic            advance;
    logic            move;

    assign advance  = !out_valid_reg || m_tready;
    assign move     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_item_next.action      = s_tuser;
    assign in_item_next.size_code   = s_tdata[2:0];
    assign in_item_next.address     = s_tdata[66:3];
    assign in_item_next.operand     = s_tdata[130:67];
    assign in_item_next.memory_data = s_tdata[194:131];
    assign in_item_next.read_fault  = s_tdata[195];
    assign in_item_next.write_fault = s_tdata[196];
    assign in_item_next.dest_reg    = s_tdata[201:197];
    assign in_item_next.inst_addr   = s_tdata[265:202];

    rvamo_exec u_exec
    (
        .item        (in_item_reg),
        .resv_valid  (resv_valid_reg),
        .resv_addr   (resv_addr_reg),
        .result      (exec_result),
        .resv_update (resv_update)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            resv_valid_reg <= 1'b0;
            resv_addr_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move && resv_update.set)
            begin
                resv_valid_reg <= 1'b1;
                resv_addr_reg  <= resv_update.address;
            end
            else if (move && resv_update.clear)
            begin
                resv_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_next;
        end
        if (move)
        begin
            out_item_reg <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.trap_kind;
    assign m_tdata  = {out_item_reg.trap_value,
                       out_item_reg.rd_value,
                       out_item_reg.rd_index,
                       out_item_reg.rd_write,
                       out_item_reg.write_data,
                       out_item_reg.mem_write,
                       out_item_reg.mem_read};

endmodule

[verif/amo_result_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// amo_result_checker
// Watches both channels of the atomic unit, predicts every result from the
// accepted instructions and its own copy of the reservation, and compares
// each delivered result field by field, in order.
// ============================================================================
module amo_result_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rvamo_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rvamo_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rvamo_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [rvamo_pkg::OUT_USER_W-1:0] m_tuser,
    output int                               mismatches,
    output int                               outstanding
);
    import rvamo_pkg::*;

    logic [XLEN-1:0] resv_address;
    logic            resv_valid;
    out_item_t       predicted_writebacks [$];

    function automatic out_item_t execute_atomic(in_item_t it);
        out_item_t       r;
        logic            word;
        logic            legal_op;
        logic            misaligned;
        logic            lt_signed;
        logic            lt_unsigned;
        logic [XLEN-1:0] mask;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] old_value;
        logic [XLEN-1:0] new_value;
        r = '0;
        r.rd_index = it.dest_reg;
        word = (it.size_code == SIZE_WORD);
        mask = word ? 64'h0000_0000_FFFF_FFFF : '1;
        a = it.memory_data & mask;
        b = it.operand & mask;
        old_value = word ? {{32{it.memory_data[31]}}, it.memory_data[31:0]} : it.memory_data;
        misaligned = word ? (it.address[1:0] != 2'b0) : (it.address[2:0] != 3'b0);
        lt_unsigned = a < b;
        lt_signed = word ? ($signed(a[31:0]) < $signed(b[31:0])) : ($signed(a) < $signed(b));
        case (it.action)
            OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR, OP_AND,
            OP_MIN, OP_MAX, OP_MINU, OP_MAXU: legal_op = 1'b1;
            default: legal_op = 1'b0;
        endcase
        if (!legal_op || (it.size_code != SIZE_WORD && it.size_code != SIZE_DOUBLE))
        begin
            r.trap_kind = TRAP_ILLEGAL;
            r.trap_value = it.inst_addr;
        end
        else if ((it.action == OP_LR || it.action == OP_SC) && misaligned)
        begin
            r.trap_kind = TRAP_MISALIGNED;
            r.trap_value = it.address;
        end
        else if (it.action == OP_LR)
        begin
            r.mem_read = 1'b1;
            if (!it.read_fault)
            begin
                r.rd_write = 1'b1;
                r.rd_value = old_value;
                resv_address = it.address;
                resv_valid = 1'b1;
            end
        end
        else if (it.action == OP_SC)
        begin
            r.rd_write = 1'b1;
            if (resv_valid && resv_address == it.address)
            begin
                r.mem_write = 1'b1;
                r.write_data = b;
                r.rd_value = {63'b0, it.write_fault};
            end
            else
            begin
                r.rd_value = 64'd1;
            end
            resv_valid = 1'b0;
        end
        else
        begin
            r.mem_read = 1'b1;
            if (!it.read_fault)
            begin
                case (it.action)
                    OP_ADD:  new_value = a + b;
                    OP_SWAP: new_value = b;
                    OP_XOR:  new_value = a ^ b;
                    OP_OR:   new_value = a | b;
                    OP_AND:  new_value = a & b;
                    OP_MIN:  new_value = lt_signed ? a : b;
                    OP_MAX:  new_value = lt_signed ? b : a;
                    OP_MINU: new_value = lt_unsigned ? a : b;
                    default: new_value = lt_unsigned ? b : a;
                endcase
                r.mem_write = 1'b1;
                r.write_data = new_value & mask;
                if (!it.write_fault)
                begin
                    r.rd_write = 1'b1;
                    r.rd_value = old_value;
                end
            end
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [XLEN-1:0] expected,
                                 logic [XLEN-1:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %h, got %h", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  instr;
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            resv_address = '0;
            resv_valid = 1'b0;
            predicted_writebacks.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.mem_read   = m_tdata[0];
                got.mem_write  = m_tdata[1];
                got.write_data = m_tdata[65:2];
                got.rd_write   = m_tdata[66];
                got.rd_index   = m_tdata[71:67];
                got.rd_value   = m_tdata[135:72];
                got.trap_value = m_tdata[199:136];
                got.trap_kind  = m_tuser;
                if (predicted_writebacks.size() == 0)
                begin
                    $error("Result transfer arrived with no prediction pending.");
                    mismatches++;
                end
                else
                begin
                    want = predicted_writebacks.pop_front();
                    compare_field("mem_read", XLEN'(want.mem_read), XLEN'(got.mem_read));
                    compare_field("mem_write", XLEN'(want.mem_write), XLEN'(got.mem_write));
                    compare_field("write_data", want.write_data, got.write_data);
                    compare_field("rd_write", XLEN'(want.rd_write), XLEN'(got.rd_write));
                    compare_field("rd_index", XLEN'(want.rd_index), XLEN'(got.rd_index));
                    compare_field("rd_value", want.rd_value, got.rd_value);
                    compare_field("trap_kind", XLEN'(want.trap_kind), XLEN'(got.trap_kind));
                    compare_field("trap_value", want.trap_value, got.trap_value);
                end
            end
            if (s_tvalid && s_tready)
            begin
                instr.action      = s_tuser;
                instr.size_code   = s_tdata[2:0];
                instr.address     = s_tdata[66:3];
                instr.operand     = s_tdata[130:67];
                instr.memory_data = s_tdata[194:131];
                instr.read_fault  = s_tdata[195];
                instr.write_fault = s_tdata[196];
                instr.dest_reg    = s_tdata[201:197];
                instr.inst_addr   = s_tdata[265:202];
                predicted_writebacks.push_back(execute_atomic(instr));
            end
        end
        outstanding = predicted_writebacks.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the atomic memory operation unit.
// ============================================================================
// Runs a directed set of LR, SC and AMO instructions covering traps, faults
// and reservation outcomes, then about a thousand random instructions built
// mostly from LR/SC pairs on a few shared addresses and AMOs on extreme data.
// Both channels idle at random; the result side is held off once to fill the
// unit, and the sender once drains everything before it continues.
// ============================================================================
module testbench;
    import rvamo_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    int                    mismatches;
    int                    outstanding;

    logic                  quiet;
    logic                  hold_request;
    logic                  hold_served;
    int                    idle_cycles;
    int                    stall_left;
    logic [XLEN-1:0]       addr_pool [4];

    riscv_atomic_memory_op_unit_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    amo_result_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] edge_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'h0000_0000_8000_0000;
            5: return 64'h0000_0000_7FFF_FFFF;
            6: return 64'hFFFF_FFFF_0000_0000;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [4:0] pick_amo();
        case ($urandom_range(0, 8))
            0: return OP_ADD;
            1: return OP_SWAP;
            2: return OP_XOR;
            3: return OP_OR;
            4: return OP_AND;
            5: return OP_MIN;
            6: return OP_MAX;
            7: return OP_MINU;
            default: return OP_MAXU;
        endcase
    endfunction

    function automatic in_item_t make_instr(logic [4:0] op, logic [2:0] size,
                                            logic [XLEN-1:0] addr, logic [XLEN-1:0] rs2,
                                            logic [XLEN-1:0] mem, logic rf, logic wf);
        in_item_t it;
        it.action      = op;
        it.size_code   = size;
        it.address     = addr;
        it.operand     = rs2;
        it.memory_data = mem;
        it.read_fault  = rf;
        it.write_fault = wf;
        it.dest_reg    = 5'($urandom);
        it.inst_addr   = rand64();
        return it;
    endfunction

    function automatic logic [XLEN-1:0] reservation_address(logic [2:0] size);
        logic [XLEN-1:0] addr;
        addr = addr_pool[$urandom_range(0, 3)];
        if (size == SIZE_WORD && $urandom_range(0, 1) == 0)
            addr[2] = 1'b1;
        if ($urandom_range(0, 19) == 0)
            addr[2:0] = 3'($urandom_range(1, 7));
        return addr;
    endfunction

    function automatic in_item_t random_instr();
        int              pick;
        logic [2:0]      size;
        logic [XLEN-1:0] addr;
        logic            rf;
        logic            wf;
        pick = $urandom_range(0, 99);
        size = ($urandom_range(0, 1) == 0) ? SIZE_WORD : SIZE_DOUBLE;
        rf = ($urandom_range(0, 9) == 0);
        wf = ($urandom_range(0, 9) == 0);
        if (pick < 55)
        begin
            addr = ($urandom_range(0, 2) == 0) ? reservation_address(size) : rand64();
            return make_instr(pick_amo(), size, addr, edge_value(), edge_value(), rf, wf);
        end
        else if (pick < 72)
            return make_instr(OP_LR, size, reservation_address(size), rand64(),
                              edge_value(), rf, wf);
        else if (pick < 88)
            return make_instr(OP_SC, size, reservation_address(size), edge_value(),
                              rand64(), rf, wf);
        else if (pick < 94)
        begin
            case ($urandom_range(0, 5))
                0: size = 3'd0;
                1: size = 3'd1;
                2: size = 3'd4;
                3: size = 3'd5;
                4: size = 3'd6;
                default: size = 3'd7;
            endcase
            return make_instr(pick_amo(), size, rand64(), rand64(), rand64(), rf, wf);
        end
        return make_instr(5'($urandom), 3'($urandom), rand64(), rand64(), rand64(), rf, wf);
    endfunction

    task automatic send_instr(in_item_t it);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tuser  = it.action;
        s_tdata  = {6'b0, it.inst_addr, it.dest_reg, it.write_fault, it.read_fault,
                    it.memory_data, it.operand, it.address, it.size_code};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Result side: short random stalls, one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            else if (quiet)
                m_tready = 1'b1;
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [XLEN-1:0] a_res;
        logic [XLEN-1:0] b_res;
        in_item_t        it;
        logic            follow_sc;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        follow_sc    = 1'b0;
        it           = '0;
        for (int i = 0; i < 4; i++)
            addr_pool[i] = rand64() & ~64'h7;
        a_res = addr_pool[0];
        b_res = addr_pool[1] | 64'h4;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reservation outcomes: success, lost reservation, address mismatch,
        // LR read fault, SC write fault.
        send_instr(make_instr(OP_LR, SIZE_DOUBLE, a_res, '0, '1, 1'b0, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_DOUBLE, a_res, '1, '0, 1'b0, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_DOUBLE, a_res, '1, '0, 1'b0, 1'b0));
        send_instr(make_instr(OP_LR, SIZE_WORD, a_res, '0, 64'h1234_5678_8000_0001, 1'b0, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_WORD, a_res | 64'h4, '1, '0, 1'b0, 1'b0));
        send_instr(make_instr(OP_LR, SIZE_WORD, b_res, '0, '1, 1'b1, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_WORD, b_res, '1, '0, 1'b0, 1'b0));
        send_instr(make_instr(OP_LR, SIZE_WORD, b_res, '0, 64'h7FFF_FFFF, 1'b0, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_WORD, b_res, 64'hFFFF_FFFF_8000_0000, '0, 1'b0, 1'b1));
        // Misaligned LR and SC, illegal size and illegal selector.
        send_instr(make_instr(OP_LR, SIZE_DOUBLE, a_res | 64'h4, '0, '1, 1'b0, 1'b0));
        send_instr(make_instr(OP_SC, SIZE_WORD, '1, '1, '1, 1'b0, 1'b0));
        send_instr(make_instr(OP_ADD, 3'd0, '1, '1, '1, 1'b0, 1'b0));
        send_instr(make_instr(5'h1F, SIZE_DOUBLE, '0, '0, '0, 1'b0, 1'b0));
        // Every AMO on sign-boundary data, with both sizes used across the set.
        send_instr(make_instr(OP_ADD, SIZE_DOUBLE, '1, '1, '1, 1'b0, 1'b0));
        send_instr(make_instr(OP_ADD, SIZE_WORD, 64'h3, 64'hFFFF_FFFF, 64'h1, 1'b0, 1'b0));
        send_instr(make_instr(OP_SWAP, SIZE_WORD, '0, '1, '0, 1'b0, 1'b0));
        send_instr(make_instr(OP_XOR, SIZE_DOUBLE, '0, 64'hAAAA_AAAA_AAAA_AAAA, '1, 1'b0, 1'b0));
        send_instr(make_instr(OP_OR, SIZE_WORD, '0, 64'h5555_5555_0000_0000,
                              64'h8000_0000, 1'b0, 1'b0));
        send_instr(make_instr(OP_AND, SIZE_DOUBLE, '0, '1, 64'h8000_0000_0000_0001, 1'b0, 1'b0));
        send_instr(make_instr(OP_MIN, SIZE_DOUBLE, '0, 64'h8000_0000_0000_0000,
                              64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
        send_instr(make_instr(OP_MAX, SIZE_DOUBLE, '0, 64'h8000_0000_0000_0000,
                              64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
        send_instr(make_instr(OP_MINU, SIZE_WORD, '0, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0, 1'b0));
        send_instr(make_instr(OP_MAXU, SIZE_DOUBLE, '0, 64'h8000_0000_0000_0000,
                              64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
        send_instr(make_instr(OP_MIN, SIZE_WORD, '0, 64'h0000_0000_8000_0000,
                              64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0));
        send_instr(make_instr(OP_MAX, SIZE_WORD, '0, 64'h0000_0000_8000_0000,
                              64'h0000_0000_7FFF_FFFF, 1'b0, 1'b1));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
            begin
                @(negedge clk);
                hold_request = 1'b1;
                quiet = 1'b1;
                for (int k = 0; k < 20; k++)
                    send_instr(random_instr());
                quiet = 1'b0;
                @(negedge clk);
                s_tvalid = 1'b0;
                wait (outstanding == 0);
            end
            if (n == RANDOM_ITEMS - 150)
                quiet = 1'b1;
            if (follow_sc)
            begin
                it = make_instr(OP_SC, it.size_code, it.address, edge_value(), rand64(),
                                1'b0, ($urandom_range(0, 9) == 0));
                follow_sc = 1'b0;
            end
            else
            begin
                it = random_instr();
                follow_sc = (it.action == OP_LR) && ($urandom_range(0, 1) == 0);
            end
            send_instr(it);
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
